[sv/md5_pkg.sv]
// Shared types, constants and round tables of the MD5 digest unit.
// No dependencies; imported by md5_message_digest_unit.
package md5_pkg;

  localparam int unsigned BUF_WORDS = 16;
  localparam int unsigned BUF_AW    = $clog2(BUF_WORDS);
  localparam logic [5:0]  LEN_OFS   = 6'd56;
  localparam logic [7:0]  PAD_MARK  = 8'h80;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_PAD   = 6'b000010,
    S_PREP  = 6'b000100,
    S_ROUND = 6'b001000,
    S_FIN   = 6'b010000,
    S_OUT   = 6'b100000
  } md5_state_t;

  // additive constant of round r
  function automatic logic [31:0] md5_k(input logic [5:0] r);
    logic [31:0] k;
    begin
      case (r)
        6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
        6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
        6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
        6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
        6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
        6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
        6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
        6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
        6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
        6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
        6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
        6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
        6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
        6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
        6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
        6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
        6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
        6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
        6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
        6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
        6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
        6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
        6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  // rotate amount of round r
  function automatic logic [4:0] md5_rot(input logic [5:0] r);
    logic [4:0] s;
    begin
      case ({r[5:4], r[1:0]})
        4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
        4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
        4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
        4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

  // message word used by round r
  function automatic logic [BUF_AW-1:0] md5_sel(input logic [5:0] r);
    logic [3:0] i;
    logic [3:0] w;
    begin
      i = r[3:0];
      case (r[5:4])
        2'd0:    w = i;
        2'd1:    w = 4'(i * 4'd5 + 4'd1);
        2'd2:    w = 4'(i * 4'd3 + 4'd5);
        default: w = 4'(i * 4'd7);
      endcase
      return BUF_AW'(w);
    end
  endfunction

endpackage

[sv/md5_in_if.sv]
// Request channel of the MD5 digest unit: one message byte and its marks.
// Stands alone; no package needed.
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

[sv/md5_out_if.sv]
// Result channel of the MD5 digest unit: the 16-byte digest in two halves.
// Stands alone; no package needed.
interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_low;
  logic [63:0] digest_high;

  modport source (output valid, digest_low, digest_high, input ready);
  modport sink   (input valid, digest_low, digest_high, output ready);
endinterface

[sv/md5_message_digest_unit.sv]
// Top level of the MD5 digest unit: byte loader, padder and round engine.
// Depends on md5_pkg, md5_in_if, md5_out_if and md5_ram.
//
// Usage:
//  - Requests arrive on 'in': data_byte is absorbed when has_byte is set;
//    end_of_message closes the message after that byte (an empty request
//    with end_of_message alone closes it too).
//  - One digest leaves on 'out' per closed message, bytes 0..7 in
//    digest_low and 8..15 in digest_high, byte i in bits 8i+7..8i.
//  - A byte that does not fill a block is simply stored. The byte that fills
//    the 64-byte block starts a compression: a PREP step to prime the buffer
//    read, 64 rounds at one per cycle, then a FIN step to add into the chain.
//    The single round unit reads one word a cycle from the block RAM; no
//    bytes are taken while a block is being compressed.
//  - After end_of_message the padder writes one byte per cycle (9 to 72
//    bytes), with one or two compressions, then the digest passes through
//    the OUT state into the output register.
//  - If the receiver stalls, the finished digest waits in the output
//    register; the next digest waits in the engine until the slot frees.
//  - Reset (synchronous) loads the initial chaining words, clears the bit
//    count and fill count and empties the output register.
module md5_message_digest_unit (
  input logic clk,
  input logic rst,
  md5_in_if.sink    in,
  md5_out_if.source out
);
  import md5_pkg::*;

  md5_state_t state;
  logic [31:0] chain_a, chain_b, chain_c, chain_d;
  logic [31:0] wa, wb, wc, wd;
  logic [63:0] message_bits;
  logic [5:0]  fill_count;
  logic [23:0] word_buf;
  logic [5:0]  round;
  logic        pad_act, pad_first, pad_last, pad_wrap;
  logic        out_valid;
  logic [63:0] out_low, out_high;

  logic              in_acc;
  logic              push_en;
  logic [7:0]        push_val;
  logic              ram_we;
  logic [BUF_AW-1:0] ram_raddr;
  logic [31:0]       ram_rdata;
  logic [31:0]       mix, sum, rot;
  logic [63:0]       rot_dbl;
  logic [4:0]        rot_n;
  logic              out_free;

  assign in.ready      = (state == S_LOAD);
  assign in_acc        = in.valid && in.ready;
  assign out.valid     = out_valid;
  assign out.digest_low  = out_low;
  assign out.digest_high = out_high;
  assign out_free      = !out_valid || out.ready;

  // byte source: the request in LOAD, padding in PAD
  always_comb begin
    push_en  = 1'b0;
    push_val = in.data_byte;
    if (state == S_LOAD) begin
      push_en = in_acc && in.has_byte;
    end else if (state == S_PAD) begin
      push_en = 1'b1;
      if (pad_first) begin
        push_val = PAD_MARK;
      end else if (fill_count < LEN_OFS || pad_wrap) begin
        push_val = 8'h00;
      end else begin
        push_val = message_bits[{fill_count[2:0], 3'b000} +: 8];
      end
    end
  end

  assign ram_we = push_en && (fill_count[1:0] == 2'd3);

  // prime with the word of round 0, then stay one round ahead
  assign ram_raddr = (state == S_ROUND) ? md5_sel(6'(round + 6'd1)) : md5_sel(6'd0);

  md5_ram #(.WIDTH(32), .DEPTH(BUF_WORDS)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_count[5:2]),
    .wdata ({push_val, word_buf}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    case (round[5:4])
      2'd0:    mix = (wb & wc) | (~wb & wd);
      2'd1:    mix = (wb & wd) | (wc & ~wd);
      2'd2:    mix = wb ^ wc ^ wd;
      default: mix = wc ^ (wb | ~wd);
    endcase
    sum     = wa + mix + md5_k(round) + ram_rdata;
    rot_n   = md5_rot(round);
    rot_dbl = {sum, sum} << rot_n;
    rot     = rot_dbl[63:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      chain_a      <= IV_A;
      chain_b      <= IV_B;
      chain_c      <= IV_C;
      chain_d      <= IV_D;
      message_bits <= '0;
      fill_count   <= '0;
      round        <= '0;
      pad_act      <= 1'b0;
      pad_first    <= 1'b0;
      pad_last     <= 1'b0;
      pad_wrap     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end

      if (push_en) begin
        fill_count <= fill_count + 6'd1;
        case (fill_count[1:0])
          2'd0:    word_buf[7:0]   <= push_val;
          2'd1:    word_buf[15:8]  <= push_val;
          2'd2:    word_buf[23:16] <= push_val;
          default: ;
        endcase
      end

      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (in.has_byte) begin
              message_bits <= message_bits + 64'd8;
            end
            if (in.end_of_message) begin
              pad_act   <= 1'b1;
              pad_first <= 1'b1;
            end
            if (in.has_byte && fill_count == 6'd63) begin
              state <= S_PREP;
            end else if (in.end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pad_first <= 1'b0;
          if (fill_count == 6'd63) begin
            // last length byte closes the message
            if (!pad_first && !pad_wrap) begin
              pad_last <= 1'b1;
            end
            pad_wrap <= 1'b0;
            state    <= S_PREP;
          end else if (pad_first) begin
            // no room for the length: zero this block, length in the next
            pad_wrap <= (fill_count >= LEN_OFS);
          end
        end
        S_PREP: begin
          wa    <= chain_a;
          wb    <= chain_b;
          wc    <= chain_c;
          wd    <= chain_d;
          round <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          wa    <= wd;
          wd    <= wc;
          wc    <= wb;
          wb    <= wb + rot;
          round <= round + 6'd1;
          if (round == 6'd63) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          chain_a <= chain_a + wa;
          chain_b <= chain_b + wb;
          chain_c <= chain_c + wc;
          chain_d <= chain_d + wd;
          if (pad_last) begin
            state <= S_OUT;
          end else if (pad_act) begin
            state <= S_PAD;
          end else begin
            state <= S_LOAD;
          end
        end
        S_OUT: begin
          // hold the digest until the output register is free
          if (out_free) begin
            out_low      <= {chain_b, chain_a};
            out_high     <= {chain_d, chain_c};
            chain_a      <= IV_A;
            chain_b      <= IV_B;
            chain_c      <= IV_C;
            chain_d      <= IV_D;
            message_bits <= '0;
            pad_act      <= 1'b0;
            pad_last     <= 1'b0;
            state        <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

[sv/md5_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module md5_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
